### rtl/accumulator_cpu_execute_assert.svh
// Assertion macros shared by the execute block's modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ACCUMULATOR_CPU_EXECUTE_ASSERT_SVH
`define ACCUMULATOR_CPU_EXECUTE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACPU_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("acpu assertion failed");
`define ACPU_ASSERT_RST(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("acpu reset check failed");
`else
`define ACPU_ASSERT(name, clk, rst_n, prop)
`define ACPU_ASSERT_RST(name, clk, prop)
`endif
`endif

### rtl/acpu_pkg.sv
`timescale 1ns / 1ps
package acpu_pkg;

	localparam int DATA_W = 8;

	// Operation codes.
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_SAV  = 4'd1;
	localparam logic [3:0] OP_LDA  = 4'd2;
	localparam logic [3:0] OP_LDB  = 4'd3;
	localparam logic [3:0] OP_STA  = 4'd4;
	localparam logic [3:0] OP_STB  = 4'd5;
	localparam logic [3:0] OP_ADD  = 4'd6;
	localparam logic [3:0] OP_SUB  = 4'd7;
	localparam logic [3:0] OP_JMP  = 4'd8;
	localparam logic [3:0] OP_JE   = 4'd9;
	localparam logic [3:0] OP_JL   = 4'd10;
	localparam logic [3:0] OP_JG   = 4'd11;
	localparam logic [3:0] OP_HALT = 4'd12;
	localparam logic [3:0] OP_CMP  = 4'd13;
	localparam logic [3:0] OP_LDI  = 4'd14;
	localparam logic [3:0] OP_AOUT = 4'd15;

	// Compare flags, one hot.
	localparam logic [2:0] FLAG_GREATER = 3'b001;
	localparam logic [2:0] FLAG_EQUAL   = 3'b010;
	localparam logic [2:0] FLAG_LESS    = 3'b100;

	typedef struct packed {
		logic [3:0]        kind;
		logic [DATA_W-1:0] operand;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] pc_now;
		logic [DATA_W-1:0] acc_a;
		logic [DATA_W-1:0] acc_b;
		logic [2:0]        flag_bits;
		logic              is_halted;
		logic              emit_valid;
		logic [DATA_W-1:0] emit_value;
	} out_t;

	// Classified instruction as it travels from the front to the back.
	typedef struct packed {
		logic [3:0]        kind;
		logic [DATA_W-1:0] operand;
		logic [DATA_W-1:0] addr;
		logic              mem_rd;
		logic              mem_wr;
	} dec_t;

endpackage

### rtl/acpu_ram.sv
`timescale 1ns / 1ps
module acpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/acpu_front.sv
`timescale 1ns / 1ps
`include "accumulator_cpu_execute_assert.svh"
module acpu_front #(
	parameter int MEM_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acpu_pkg::in_t  in_data,
	output logic           q_valid,
	input  logic           q_pop,
	output acpu_pkg::dec_t q_data
);

	typedef logic [acpu_pkg::DATA_W-1:0] mod_tbl_t [256];

	// Operand to memory address, folded modulo the memory depth.
	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t t;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = acpu_pkg::DATA_W'(r);
			if (r == MEM_DEPTH - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return t;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	acpu_pkg::dec_t dec;
	acpu_pkg::dec_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;

	always_comb begin
		dec.kind    = in_data.kind;
		dec.operand = in_data.operand;
		dec.addr    = MOD_TBL[in_data.operand];
		dec.mem_rd  = (in_data.kind == acpu_pkg::OP_LDA) || (in_data.kind == acpu_pkg::OP_LDB);
		dec.mem_wr  = (in_data.kind == acpu_pkg::OP_STA) || (in_data.kind == acpu_pkg::OP_STB);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`ACPU_ASSERT(a_queue_bound, clk, arst_n, cnt_q <= 2'd2)
	`ACPU_ASSERT(a_pop_not_empty, clk, arst_n, q_pop |-> cnt_q != 2'd0)

endmodule

### rtl/acpu_back.sv
`timescale 1ns / 1ps
`include "accumulator_cpu_execute_assert.svh"
module acpu_back #(
	parameter int MEM_DEPTH = 256,
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  acpu_pkg::dec_t q_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acpu_pkg::out_t out_data
);

	localparam int DW = acpu_pkg::DATA_W;

	// Architectural state.
	logic [DW-1:0]        pc_q;
	logic [DW-1:0]        a_q;
	logic [DW-1:0]        b_q;
	logic [2:0]           flags_q;
	logic                 halt_q;
	logic [MEM_DEPTH-1:0] mvalid_q;

	// Execute stage.
	logic                 vld_s1;
	acpu_pkg::dec_t       ex_s1;
	logic                 mvld_s1;
	logic                 fwd_s1;
	logic [DW-1:0]        fwd_data_s1;

	// Result register.
	logic                 out_valid_q;
	acpu_pkg::out_t       out_q;

	logic                 adv;
	logic                 mem_we;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [DW-1:0]        st_data;
	logic [DW-1:0]        ram_rdata;
	logic [DW-1:0]        ld_data;

	logic [DW-1:0]        n_pc;
	logic [DW-1:0]        n_a;
	logic [DW-1:0]        n_b;
	logic [2:0]           n_flags;
	logic                 n_halt;
	logic                 n_emit;
	logic                 jump;

	assign adv     = vld_s1 && (!out_valid_q || out_ready);
	assign q_pop   = q_valid && (!vld_s1 || adv);
	assign raddr   = q_data.addr[AW-1:0];
	assign waddr   = ex_s1.addr[AW-1:0];
	assign st_data = (ex_s1.kind == acpu_pkg::OP_STA) ? a_q : b_q;
	assign mem_we  = adv && ex_s1.mem_wr && !halt_q;

	acpu_ram #(
		.WIDTH(DW),
		.DEPTH(MEM_DEPTH)
	) u_dmem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr),
		.wdata(st_data),
		.re   (q_pop && q_data.mem_rd),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// A store retiring in the cycle of the read is not yet in the RAM output.
	assign ld_data = fwd_s1 ? fwd_data_s1 : (mvld_s1 ? ram_rdata : '0);

	always_comb begin
		n_a     = a_q;
		n_b     = b_q;
		n_flags = flags_q;
		n_halt  = halt_q;
		n_emit  = 1'b0;
		jump    = 1'b0;
		n_pc    = pc_q;
		if (!halt_q) begin
			unique case (ex_s1.kind)
				acpu_pkg::OP_NOP: begin
				end
				acpu_pkg::OP_SAV:  n_b = a_q;
				acpu_pkg::OP_LDA:  n_a = ld_data;
				acpu_pkg::OP_LDB:  n_b = ld_data;
				acpu_pkg::OP_STA: begin
				end
				acpu_pkg::OP_STB: begin
				end
				acpu_pkg::OP_ADD:  n_a = a_q + b_q;
				acpu_pkg::OP_SUB:  n_a = a_q - b_q;
				acpu_pkg::OP_JMP:  jump = 1'b1;
				acpu_pkg::OP_JE:   jump = |(flags_q & acpu_pkg::FLAG_EQUAL);
				acpu_pkg::OP_JL:   jump = |(flags_q & acpu_pkg::FLAG_LESS);
				acpu_pkg::OP_JG:   jump = |(flags_q & acpu_pkg::FLAG_GREATER);
				acpu_pkg::OP_HALT: n_halt = 1'b1;
				acpu_pkg::OP_CMP: begin
					if (a_q == b_q) begin
						n_flags = acpu_pkg::FLAG_EQUAL;
					end else if (a_q < b_q) begin
						n_flags = acpu_pkg::FLAG_LESS;
					end else begin
						n_flags = acpu_pkg::FLAG_GREATER;
					end
				end
				acpu_pkg::OP_LDI:  n_a = ex_s1.operand;
				acpu_pkg::OP_AOUT: n_emit = 1'b1;
			endcase
			n_pc = jump ? ex_s1.operand : pc_q + DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ex_s1       <= q_data;
			mvld_s1     <= mvalid_q[raddr];
			fwd_s1      <= mem_we && (waddr == raddr);
			fwd_data_s1 <= st_data;
		end
		if (adv) begin
			out_q.pc_now     <= n_pc;
			out_q.acc_a      <= n_a;
			out_q.acc_b      <= n_b;
			out_q.flag_bits  <= n_flags;
			out_q.is_halted  <= n_halt;
			out_q.emit_valid <= n_emit;
			out_q.emit_value <= n_emit ? a_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			flags_q     <= '0;
			halt_q      <= 1'b0;
			mvalid_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				pc_q        <= n_pc;
				a_q         <= n_a;
				b_q         <= n_b;
				flags_q     <= n_flags;
				halt_q      <= n_halt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				mvalid_q[waddr] <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ACPU_ASSERT(a_flags_onehot, clk, arst_n, $onehot0(flags_q))
	`ACPU_ASSERT(a_halt_freezes_pc, clk, arst_n, halt_q |=> $stable(pc_q))
	`ACPU_ASSERT(a_quiet_emit_zero, clk, arst_n, out_valid_q && !out_q.emit_valid |-> out_q.emit_value == '0)
	`ACPU_ASSERT_RST(a_reset_out_idle, clk, !arst_n |=> !out_valid_q)

endmodule

### rtl/accumulator_cpu_execute.sv
`timescale 1ns / 1ps
// A result passes through the front queue, the execute stage register and the result
// register before it is offered. Throughput: one instruction per cycle while out_ready is
// high, set by the execute stage and the registered memory read issued at each pop.
// Reset (arst_n low, asynchronous) clears PC, A, B, flags, halt and the memory valid bits
// at once, so the data memory reads as zero right away; there is no clearing pass.
module accumulator_cpu_execute #(
	parameter int MEM_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acpu_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acpu_pkg::out_t out_data
);

	// The front takes each input transfer, classifies the instruction (memory read,
	// memory write) and folds the operand into a memory address. Classified
	// instructions wait in a two-entry queue, so the input side keeps taking
	// transfers while the result side is stalled, until the queue is full.
	logic           q_valid;
	logic           q_pop;
	acpu_pkg::dec_t q_data;

	acpu_front #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data)
	);

	// The back pops one instruction per cycle while the result register can drain,
	// starts the data memory read on the pop, and executes the staged instruction
	// against the architectural registers. A store retiring in the same cycle as
	// a pop to the same address is forwarded into the load path. Each executed
	// instruction lands in the result register, which the output transfer drains.
	acpu_back #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

### tb/accumulator_cpu_execute_tb.sv
`timescale 1ns / 1ps
module accumulator_cpu_execute_tb;

	// The data memory keeps its full size here, so every operand byte is a distinct address.
	localparam int MEM_DEPTH = 256;
	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 10;
	localparam int ITEMS_PER_PHASE = 300;
	// Long enough to fill every stage and queue slot behind the output and stall the input.
	localparam int HOLD_CYCLES = 64;
	// Long enough for any result still in the block to come out; this leaves margin.
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] FLAG_NONE = 3'b000;

	// Rows of the directed program. A row either carries the machine state that can be read
	// off at a glance, or leaves the expectation to the predictor.
	typedef struct packed {
		acpu_pkg::in_t  stim;
		logic           fixed;
		acpu_pkg::out_t want;
	} dir_row_t;

	localparam acpu_pkg::out_t NO_FIX = '0;
	localparam int N_HEAD = 23;
	localparam int N_DIR = 28;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		// Straight after reset everything reads zero and no flag is set, so the three
		// conditional jumps fall through and a load from memory returns zero.
		'{'{acpu_pkg::OP_NOP,  8'h00}, 1'b1,
			'{8'h01, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_JE,   8'h55}, 1'b1,
			'{8'h02, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_JL,   8'hAA}, 1'b1,
			'{8'h03, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_JG,   8'hFF}, 1'b1,
			'{8'h04, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_LDA,  8'hFF}, 1'b1,
			'{8'h05, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_AOUT, 8'h00}, 1'b1,
			'{8'h06, 8'h00, 8'h00, FLAG_NONE, 1'b0, 1'b1, 8'h00}},
		// Largest values: the top address round trip, then an add that wraps.
		'{'{acpu_pkg::OP_LDI,  8'hFF}, 1'b1,
			'{8'h07, 8'hFF, 8'h00, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_STA,  8'hFF}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_LDB,  8'hFF}, 1'b1,
			'{8'h09, 8'hFF, 8'hFF, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_ADD,  8'h00}, 1'b1,
			'{8'h0A, 8'hFE, 8'hFF, FLAG_NONE, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_CMP,  8'h00}, 1'b1,
			'{8'h0B, 8'hFE, 8'hFF, acpu_pkg::FLAG_LESS, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_JL,   8'h00}, 1'b1,
			'{8'h00, 8'hFE, 8'hFF, acpu_pkg::FLAG_LESS, 1'b0, 1'b0, 8'h00}},
		// A subtract that borrows, then an equal compare and a jump to the top address.
		'{'{acpu_pkg::OP_SUB,  8'h00}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_CMP,  8'h00}, 1'b1,
			'{8'h02, 8'hFF, 8'hFF, acpu_pkg::FLAG_EQUAL, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_JE,   8'hFF}, 1'b1,
			'{8'hFF, 8'hFF, 8'hFF, acpu_pkg::FLAG_EQUAL, 1'b0, 1'b0, 8'h00}},
		// The program counter wraps from the top back to zero.
		'{'{acpu_pkg::OP_LDI,  8'h00}, 1'b1,
			'{8'h00, 8'h00, 8'hFF, acpu_pkg::FLAG_EQUAL, 1'b0, 1'b0, 8'h00}},
		'{'{acpu_pkg::OP_SAV,  8'h00}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_STB,  8'h80}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_LDI,  8'h01}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_CMP,  8'h00}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_JG,   8'h80}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_JMP,  8'h7F}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_AOUT, 8'hFF}, 1'b0, NO_FIX},
		// Tail, walked after the random part: halt, then a few items that must change nothing.
		'{'{acpu_pkg::OP_HALT, 8'h00}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_LDI,  8'hA5}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_JMP,  8'h10}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_STA,  8'h00}, 1'b0, NO_FIX},
		'{'{acpu_pkg::OP_AOUT, 8'h00}, 1'b0, NO_FIX}
	};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	acpu_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	acpu_pkg::out_t out_data;

	// Architectural state as the predictor sees it.
	logic [7:0] arch_pc = '0;
	logic [7:0] arch_a = '0;
	logic [7:0] arch_b = '0;
	logic [2:0] arch_flags = FLAG_NONE;
	logic       arch_halted = 1'b0;
	logic [7:0] arch_mem [MEM_DEPTH];

	// Machine states of instructions already transferred in, oldest first.
	acpu_pkg::out_t retire_queue [$];
	int             mismatches = 0;

	// Pacing knobs, in percent of cycles spent idle on each side.
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req = 1'b0;
	int   hold_count = 0;

	always #(CLK_HALF) clk = ~clk;

	accumulator_cpu_execute #(
		.MEM_DEPTH(MEM_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Executes one instruction on the architectural copy and returns the state after it.
	// Once halted, nothing changes and the frozen state is reported with no emit.
	function automatic acpu_pkg::out_t execute_instr(acpu_pkg::in_t ins);
		acpu_pkg::out_t res;
		logic           take;
		logic [7:0]     addr;
		res = '0;
		take = 1'b0;
		addr = 8'(ins.operand % MEM_DEPTH);
		if (!arch_halted) begin
			case (ins.kind)
				acpu_pkg::OP_SAV: arch_b = arch_a;
				acpu_pkg::OP_LDA: arch_a = arch_mem[addr];
				acpu_pkg::OP_LDB: arch_b = arch_mem[addr];
				acpu_pkg::OP_STA: arch_mem[addr] = arch_a;
				acpu_pkg::OP_STB: arch_mem[addr] = arch_b;
				acpu_pkg::OP_ADD: arch_a = arch_a + arch_b;
				acpu_pkg::OP_SUB: arch_a = arch_a - arch_b;
				acpu_pkg::OP_JMP: take = 1'b1;
				acpu_pkg::OP_JE: take = (arch_flags & acpu_pkg::FLAG_EQUAL) != FLAG_NONE;
				acpu_pkg::OP_JL: take = (arch_flags & acpu_pkg::FLAG_LESS) != FLAG_NONE;
				acpu_pkg::OP_JG: take = (arch_flags & acpu_pkg::FLAG_GREATER) != FLAG_NONE;
				acpu_pkg::OP_HALT: arch_halted = 1'b1;
				acpu_pkg::OP_CMP: begin
					if (arch_a == arch_b)
						arch_flags = acpu_pkg::FLAG_EQUAL;
					else if (arch_a < arch_b)
						arch_flags = acpu_pkg::FLAG_LESS;
					else
						arch_flags = acpu_pkg::FLAG_GREATER;
				end
				acpu_pkg::OP_LDI: arch_a = ins.operand;
				acpu_pkg::OP_AOUT: begin
					res.emit_valid = 1'b1;
					res.emit_value = arch_a;
				end
				default: ;
			endcase
			arch_pc = take ? ins.operand : arch_pc + 8'd1;
		end
		res.pc_now = arch_pc;
		res.acc_a = arch_a;
		res.acc_b = arch_b;
		res.flag_bits = arch_flags;
		res.is_halted = arch_halted;
		return res;
	endfunction

	// Offers one instruction, after a random gap, and holds it until the transfer. The
	// expectation is queued at the transfer edge: the typed-in state where the row has one,
	// otherwise the predictor's. The predictor runs in both cases to keep its state current.
	task automatic send_instr(input logic [3:0] kind, input logic [7:0] operand,
			input logic use_fixed, input acpu_pkg::out_t fixed_res);
		acpu_pkg::in_t  ins;
		acpu_pkg::out_t pred;
		ins.kind = kind;
		ins.operand = operand;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ins;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = execute_instr(ins);
		retire_queue.push_back(use_fixed ? fixed_res : pred);
	endtask

	// Mostly short well-formed programs with random content: compare and branch, a memory
	// round trip, and arithmetic followed by an output. The rest are single random
	// instructions. Halt is left out so that the machine keeps running until the tail.
	task automatic run_random_phase(input int n_items);
		int sent;
		int pick;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] addr;
		logic [3:0] k;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(9);
			x = 8'($urandom);
			// Equal operands come up often enough to exercise the equal flag.
			y = ($urandom_range(3) == 0) ? x : 8'($urandom);
			// Half the accesses go to a few addresses so that loads find earlier stores.
			addr = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
			if (pick < 2) begin
				case ($urandom_range(2))
					0: k = acpu_pkg::OP_JE;
					1: k = acpu_pkg::OP_JL;
					default: k = acpu_pkg::OP_JG;
				endcase
				send_instr(acpu_pkg::OP_LDI, x, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_SAV, 8'($urandom), 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_LDI, y, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_CMP, 8'($urandom), 1'b0, NO_FIX);
				send_instr(k, 8'($urandom), 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_AOUT, 8'($urandom), 1'b0, NO_FIX);
				sent += 6;
			end else if (pick < 4) begin
				send_instr(acpu_pkg::OP_LDI, x, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_STA, addr, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_LDI, y, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_LDB, addr, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_STB, addr ^ 8'h01, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_LDA, addr ^ 8'h01, 1'b0, NO_FIX);
				sent += 6;
			end else if (pick < 6) begin
				send_instr(acpu_pkg::OP_LDI, x, 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_SAV, 8'($urandom), 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_LDI, y, 1'b0, NO_FIX);
				send_instr(($urandom_range(1) == 0) ? acpu_pkg::OP_ADD : acpu_pkg::OP_SUB,
					8'($urandom), 1'b0, NO_FIX);
				send_instr(acpu_pkg::OP_AOUT, 8'($urandom), 1'b0, NO_FIX);
				sent += 5;
			end else begin
				k = 4'($urandom_range(14));
				if (k >= acpu_pkg::OP_HALT)
					k = k + 4'd1;
				send_instr(k, (k == acpu_pkg::OP_LDI) ? x : addr, 1'b0, NO_FIX);
				sent += 1;
			end
		end
	endtask

	// Output side. Each result transfer is checked against the oldest queued state, and the
	// ready for the next edge is chosen here too: either the long hold-off, counted in this
	// process, or random idling at the current rate.
	always @(posedge clk) begin
		acpu_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (retire_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result with no instruction pending, pc=%h a=%h",
							$realtime, out_data.pc_now, out_data.acc_a);
				end else begin
					want = retire_queue.pop_front();
					if (out_data.pc_now !== want.pc_now || out_data.acc_a !== want.acc_a ||
							out_data.acc_b !== want.acc_b ||
							out_data.flag_bits !== want.flag_bits ||
							out_data.is_halted !== want.is_halted ||
							out_data.emit_valid !== want.emit_valid ||
							out_data.emit_value !== want.emit_value) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected pc=%h a=%h b=%h flags=%b halt=%b emit=%b/%h",
								$realtime, want.pc_now, want.acc_a, want.acc_b,
								want.flag_bits, want.is_halted, want.emit_valid,
								want.emit_value);
							$display("%0t:      got pc=%h a=%h b=%h flags=%b halt=%b emit=%b/%h",
								$realtime, out_data.pc_now, out_data.acc_a, out_data.acc_b,
								out_data.flag_bits, out_data.is_halted, out_data.emit_valid,
								out_data.emit_value);
						end
					end
				end
			end
			if (hold_req && hold_count < HOLD_CYCLES) begin
				hold_count <= hold_count + 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++)
			arch_mem[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_HEAD; i++)
			send_instr(DIR_TAB[i].stim.kind, DIR_TAB[i].stim.operand, DIR_TAB[i].fixed,
				DIR_TAB[i].want);

		// Sender sparse and receiver mostly stalled, then the other way round.
		send_idle_pct = 34;
		recv_idle_pct = 81;
		run_random_phase(ITEMS_PER_PHASE);
		send_idle_pct = 81;
		recv_idle_pct = 34;
		run_random_phase(ITEMS_PER_PHASE);

		// Full rate on both sides, opened by a long receiver hold-off while the sender keeps
		// offering, so the block backs up and drops its input ready.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_random_phase(ITEMS_PER_PHASE);

		for (int i = N_HEAD; i < N_DIR; i++)
			send_instr(DIR_TAB[i].stim.kind, DIR_TAB[i].stim.operand, DIR_TAB[i].fixed,
				DIR_TAB[i].want);
		in_valid <= 1'b0;

		while (retire_queue.size() != 0)
			@(posedge clk);
		// Any result that shows up now has no instruction behind it and counts as a failure.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && retire_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// This bound lies far above the length of a correct run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/acpu_pkg.sv
rtl/acpu_ram.sv
rtl/acpu_front.sv
rtl/acpu_back.sv
rtl/accumulator_cpu_execute.sv
tb/accumulator_cpu_execute_tb.sv
